FILE: hw/rtl/ezwpd_pkg.sv
// ---------------------------------------------------------------------------
// ezwpd_pkg
// Types and constants of the energy / zero-crossing wake pattern detector.
// ---------------------------------------------------------------------------
`default_nettype none

package ezwpd_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned EnergyW  = 16;
  localparam int unsigned ZcrW     = 16;
  localparam int unsigned StateW   = 3;
  localparam int unsigned TotalW   = 32;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned VoicedW  = 16;

  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_COOLDOWN  = 1'b1;

  localparam logic [CfgW-1:0] THRESHOLD_RST = 16'd500;
  localparam logic [CfgW-1:0] COOLDOWN_RST  = 16'd2000;

  localparam logic [TimeW-1:0] LONG_MS     = 32'd1500;
  localparam logic [TimeW-1:0] MIN_FALL_MS = 32'd300;
  localparam logic [TimeW-1:0] MAX_FALL_MS = 32'd1200;
  localparam logic [VoicedW-1:0] SUSTAIN_FRAMES = 16'd3;
  localparam logic [VoicedW-1:0] DETECT_FRAMES  = 16'd5;

  typedef enum logic [StateW-1:0] {
    PAT_IDLE      = 3'd0,
    PAT_RISING    = 3'd1,
    PAT_SUSTAINED = 3'd2,
    PAT_FALLING   = 3'd3,
    PAT_DETECTED  = 3'd4
  } pat_e;

  typedef enum logic [2:0] {
    CT_IDLE,
    CT_SQUARE,
    CT_DIV_E,
    CT_SQRT,
    CT_DIV_Z,
    CT_EMIT
  } ctl_e;

endpackage

`default_nettype wire

FILE: hw/rtl/ezwpd_ram.sv
// ---------------------------------------------------------------------------
// ezwpd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ezwpd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/energy_zcr_wake_pattern_detector.sv
// ---------------------------------------------------------------------------
// energy_zcr_wake_pattern_detector
// Frame RMS energy and zero-crossing rate with a wake pattern state machine.
// ---------------------------------------------------------------------------
// channel   dir  tdata (low bit up)                          tlast
// s_axis    in   sample[15:0], time_ms[47:16]                frame_end
// m_axis    out  wake[0], frame_energy[16:1], frame_zcr[32:17],
//                pattern_state[35:33], detection_total[67:36] -
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// A sample is accepted and then squared in a bit-serial 16-step square;
// no new sample is taken until the block is idle again. A frame-end
// sample adds 2*SSW division steps (energy and ZCR share one restoring
// divider), 16 square-root steps and a decision state (CT_EMIT).
// The result waits in an output register; a stalled output holds the
// next frame end in its decision state. Reset clears all control and
// ring valid bits at once.
// ---------------------------------------------------------------------------
`default_nettype none

module energy_zcr_wake_pattern_detector #(
  parameter int unsigned MAX_FRAME  = 512,
  parameter int unsigned RING_DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ezwpd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [ezwpd_pkg::CfgW-1:0]       cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [47:0]                      s_axis_tdata,  // sample, time_ms
  input  wire logic                             s_axis_tlast,  // frame_end
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [71:0]                      m_axis_tdata   // wake, frame_energy,
                                                               // frame_zcr, pattern_state,
                                                               // detection_total
);
  import ezwpd_pkg::*;

  localparam int unsigned CNTW = $clog2(MAX_FRAME + 1);
  localparam int unsigned SSW  = 31 + $clog2(MAX_FRAME);
  localparam int unsigned STW  = $clog2(SSW);
  localparam int unsigned RPW  = $clog2(RING_DEPTH);
  localparam int unsigned RSW  = EnergyW + RPW;
  localparam int unsigned CMW  = RSW + 3;

  // configuration
  logic [CfgW-1:0] thr_q, cool_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THRESHOLD_RST;
      cool_q <= COOLDOWN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD: thr_q  <= cfg_data_i;
        CFG_COOLDOWN:  cool_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  ctl_e ctl_q, ctl_d;
  logic [STW-1:0] step_q;
  logic           step_last;
  logic           in_fire, emit_fire, out_free;

  logic [SampleW-1:0] raw;
  logic               neg;
  logic [SampleW-1:0] mag;
  assign raw = s_axis_tdata[15:0];
  assign neg = raw[SampleW-1];
  assign mag = neg ? (~raw + 16'd1) : raw;

  // frame accumulators
  logic [SSW-1:0]  sq_sum_q;
  logic [CNTW-1:0] cross_q, cnt_q, cnt_div;
  logic            prev_neg_q, skip_q, last_q;
  logic [TimeW-1:0] now_q;
  logic [31:0]     mcand_q;
  logic [SampleW-1:0] mplier_q;

  // shared divider and sqrt
  logic [SSW-1:0]  dvd_q;
  logic [CNTW-1:0] rem_q;
  logic [CNTW:0]   rem_sh;
  logic            q_bit;
  logic [31:0]     sv_q;
  logic [17:0]     srem_q;
  logic [19:0]     srem_sh, s_trial;
  logic [EnergyW-1:0] root_q, energy_q;
  logic            s_bit;

  assign cnt_div = (cnt_q == '0) ? CNTW'(1) : cnt_q;
  assign rem_sh  = {rem_q, dvd_q[SSW-1]};
  assign q_bit   = rem_sh >= {1'b0, cnt_div};
  assign srem_sh = {srem_q, sv_q[31:30]};
  assign s_trial = {2'b00, root_q, 2'b01};
  assign s_bit   = srem_sh >= s_trial;

  always_comb begin
    case (ctl_q)
      CT_SQUARE, CT_SQRT: step_last = step_q == STW'(15);
      default:            step_last = step_q == STW'(SSW - 1);
    endcase
  end

  // next state
  always_comb begin
    ctl_d = ctl_q;
    case (ctl_q)
      CT_IDLE:   if (in_fire) ctl_d = CT_SQUARE;
      CT_SQUARE: if (step_last) ctl_d = last_q ? CT_DIV_E : CT_IDLE;
      CT_DIV_E:  if (step_last) ctl_d = CT_SQRT;
      CT_SQRT:   if (step_last) ctl_d = CT_DIV_Z;
      CT_DIV_Z:  if (step_last) ctl_d = CT_EMIT;
      CT_EMIT:   if (out_free) ctl_d = CT_IDLE;
      default:   ctl_d = CT_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    out_free      = !m_axis_tvalid || m_axis_tready;
    s_axis_tready = ctl_q == CT_IDLE;
    in_fire       = s_axis_tvalid && s_axis_tready;
    emit_fire     = (ctl_q == CT_EMIT) && out_free;
  end

  // ring of energies
  logic [RPW-1:0]        pos_q;
  logic [RING_DEPTH-1:0] ring_vld_q;
  logic [EnergyW-1:0]    ring_rd, ring_old;
  logic [RSW-1:0]        ring_sum_q, ring_sum_new;

  ezwpd_ram #(.WIDTH(EnergyW), .DEPTH(RING_DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (emit_fire),
    .waddr_i (pos_q),
    .wdata_i (energy_q),
    .raddr_i (pos_q),
    .rdata_o (ring_rd)
  );

  assign ring_old     = ring_vld_q[pos_q] ? ring_rd : '0;
  assign ring_sum_new = ring_sum_q - RSW'(ring_old) + RSW'(energy_q);

  // pattern decision
  pat_e pat_q, pat_d;
  logic [VoicedW-1:0] voiced_q, voiced_d, voiced_inc;
  logic [TimeW-1:0]   start_q, start_d, last_wake_q, elapsed;
  logic [TotalW-1:0]  total_q;
  logic               done, wake;
  logic [CMW-1:0]     e_w, t_w, cr_w, cn_w;
  logic [ZcrW-1:0]    zcr;

  assign e_w     = CMW'(energy_q);
  assign t_w     = CMW'(thr_q);
  assign cr_w    = CMW'(cross_q);
  assign cn_w    = CMW'(cnt_div);
  assign zcr     = dvd_q[ZcrW-1:0];
  assign elapsed = now_q - start_q;
  assign voiced_inc = (voiced_q != 16'hFFFF) ? voiced_q + 16'd1 : voiced_q;

  always_comb begin
    pat_d    = pat_q;
    voiced_d = voiced_q;
    start_d  = start_q;
    done     = 1'b0;
    case (pat_q)
      PAT_IDLE: begin
        if (e_w > t_w && e_w * CMW'(2 * RING_DEPTH) > CMW'(ring_sum_new) * CMW'(3)) begin
          pat_d    = PAT_RISING;
          start_d  = now_q;
          voiced_d = '0;
        end
      end
      PAT_RISING: begin
        if (e_w * CMW'(5) > t_w * CMW'(4) && cr_w * CMW'(50) > cn_w &&
            cr_w * CMW'(5) < cn_w) begin
          voiced_d = voiced_inc;
          if (voiced_inc >= SUSTAIN_FRAMES) pat_d = PAT_SUSTAINED;
        end else if (e_w * CMW'(10) < t_w * CMW'(3)) begin
          pat_d = PAT_IDLE;
        end
      end
      PAT_SUSTAINED: begin
        if (e_w * CMW'(2) > t_w) begin
          voiced_d = voiced_inc;
          if (elapsed > LONG_MS) pat_d = PAT_IDLE;
        end else begin
          pat_d = PAT_FALLING;
        end
      end
      PAT_FALLING: begin
        if (elapsed >= MIN_FALL_MS && elapsed <= MAX_FALL_MS && voiced_q >= DETECT_FRAMES) begin
          pat_d = PAT_DETECTED;
          done  = 1'b1;
        end else begin
          pat_d = PAT_IDLE;
        end
      end
      default: pat_d = PAT_IDLE;
    endcase
    wake = done && ((now_q - last_wake_q) >= TimeW'(cool_q));
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q         <= CT_IDLE;
      step_q        <= '0;
      cross_q       <= '0;
      cnt_q         <= '0;
      prev_neg_q    <= 1'b0;
      sq_sum_q      <= '0;
      pos_q         <= '0;
      ring_vld_q    <= '0;
      ring_sum_q    <= '0;
      pat_q         <= PAT_IDLE;
      voiced_q      <= '0;
      start_q       <= '0;
      last_wake_q   <= '0;
      total_q       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      ctl_q <= ctl_d;
      if (ctl_d != ctl_q) step_q <= '0;
      else                step_q <= step_q + STW'(1);

      if (emit_fire)          m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;

      if (in_fire && cnt_q < CNTW'(MAX_FRAME)) begin
        if (cnt_q != '0 && neg != prev_neg_q) cross_q <= cross_q + CNTW'(1);
        prev_neg_q <= neg;
        cnt_q      <= cnt_q + CNTW'(1);
      end

      if (ctl_q == CT_SQUARE && !skip_q && mplier_q[0]) begin
        sq_sum_q <= sq_sum_q + SSW'(mcand_q);
      end

      if (emit_fire) begin
        ring_sum_q       <= ring_sum_new;
        ring_vld_q[pos_q] <= 1'b1;
        pos_q            <= (pos_q == RPW'(RING_DEPTH - 1)) ? '0 : pos_q + RPW'(1);
        pat_q            <= pat_d;
        voiced_q         <= voiced_d;
        start_q          <= start_d;
        if (wake) begin
          last_wake_q <= now_q;
          total_q     <= total_q + TotalW'(1);
        end
        sq_sum_q   <= '0;
        cross_q    <= '0;
        cnt_q      <= '0;
        prev_neg_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mcand_q  <= {16'd0, mag};
      mplier_q <= mag;
      skip_q   <= !(cnt_q < CNTW'(MAX_FRAME));
      last_q   <= s_axis_tlast;
      if (s_axis_tlast) now_q <= s_axis_tdata[47:16];
    end

    case (ctl_q)
      CT_SQUARE: begin
        mcand_q  <= {mcand_q[30:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[SampleW-1:1]};
        if (step_last) begin
          dvd_q <= sq_sum_q + ((!skip_q && mplier_q[0]) ? SSW'(mcand_q) : '0);
          rem_q <= '0;
        end
      end
      CT_DIV_E, CT_DIV_Z: begin
        dvd_q <= {dvd_q[SSW-2:0], q_bit};
        rem_q <= q_bit ? CNTW'(rem_sh - {1'b0, cnt_div}) : rem_sh[CNTW-1:0];
        if (ctl_q == CT_DIV_E && step_last) begin
          sv_q   <= {dvd_q[30:0], q_bit};
          srem_q <= '0;
          root_q <= '0;
        end
      end
      CT_SQRT: begin
        sv_q   <= {sv_q[29:0], 2'b00};
        srem_q <= s_bit ? 18'(srem_sh - s_trial) : srem_sh[17:0];
        root_q <= {root_q[EnergyW-2:0], s_bit};
        if (step_last) begin
          energy_q <= {root_q[EnergyW-2:0], s_bit};
          dvd_q    <= SSW'({cross_q, 16'd0});
          rem_q    <= '0;
        end
      end
      default: ;
    endcase

    if (emit_fire) begin
      m_axis_tdata <= {4'd0,
                       wake ? total_q + TotalW'(1) : total_q,
                       pat_d, zcr, energy_q, wake};
    end
  end

endmodule

`default_nettype wire
